// ----- rtl/trds_pkg.sv -----
// ----------------------------------------------------------------------------
// Thumbstick radial dead zone package
// Shared constants, pipeline payload types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package trds_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int ROOT_STEPS   = 24;
    localparam int DIV_STEPS    = 17;

    localparam logic [14:0] DEAD_ZONE_RST = 15'd10813;
    localparam logic [13:0] SNAP_RST      = 14'd1820;
    localparam logic [14:0] FULL_SCALE    = 15'd32767;
    localparam logic [31:0] FULL_SCALE_SQ = 32'd1073676289;
    localparam logic [16:0] MAG_ONE       = 17'd32768;

    typedef enum logic {
        REG_DEAD_ZONE  = 1'b0,
        REG_SNAP_ANGLE = 1'b1
    } t_reg_idx;

    // One lane of a restoring divider: partial remainder, numerator bits
    // still to be shifted in, divisor and the quotient built so far.
    typedef struct packed {
        logic [23:0] rem;
        logic [16:0] nb;
        logic [23:0] den;
        logic [16:0] quo;
    } t_div;

    typedef struct packed {
        logic signed [15:0]      x;
        logic signed [15:0]      y;
        logic [14:0]             d;
        logic [13:0]             snap;
        logic [30:0]             xx;
        logic [30:0]             yy;
        logic [29:0]             dd;
        logic                    dead;
        logic                    big;
        logic                    zero;
        logic [25:0]             sq_rem;
        logic [23:0]             sq_root;
        logic [47:0]             sq_v;
        logic signed [27:0]      cx;
        logic signed [27:0]      cy;
        logic [31:0]             cz;
        logic [ANGLE_BITS-1:0]   ang;
        t_div [1:0]              lane;
        logic [16:0]             mag;
        logic [30:0]             px;
        logic [30:0]             py;
        logic                    snap_hit;
        logic [1:0]              snap_dir;
    } t_pipe;

    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051D;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2F9;
            5'd15:   v = 32'h0000517C;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A2F;
            5'd19:   v = 32'h00000517;
            5'd20:   v = 32'h0000028B;
            5'd21:   v = 32'h00000145;
            5'd22:   v = 32'h000000A2;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/trds_root_cell.sv -----
// ----------------------------------------------------------------------------
// Root cell
// One pipeline cell: one bit of the integer square root and one CORDIC
// vectoring rotation, registered toward the next cell.
// ----------------------------------------------------------------------------
module trds_root_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic [4:0]     i_idx,
    input  logic           i_vld,
    input  trds_pkg::t_pipe i_data,
    output logic           o_vld,
    output trds_pkg::t_pipe o_data
);
    import trds_pkg::*;

    t_pipe              n_data;
    logic [27:0]        w_rem2;
    logic [27:0]        w_trial;
    logic               w_ge;
    logic signed [27:0] w_sx;
    logic signed [27:0] w_sy;

    always_comb begin
        n_data  = i_data;
        // Bring in the next two radicand bits and try the next root bit.
        w_rem2  = {i_data.sq_rem, i_data.sq_v[47:46]};
        w_trial = {2'b00, i_data.sq_root, 2'b01};
        w_ge    = (w_rem2 >= w_trial);
        n_data.sq_rem  = w_ge ? 26'(w_rem2 - w_trial) : w_rem2[25:0];
        n_data.sq_root = {i_data.sq_root[22:0], w_ge};
        n_data.sq_v    = {i_data.sq_v[45:0], 2'b00};

        w_sx = i_data.cx >>> i_idx;
        w_sy = i_data.cy >>> i_idx;
        if (!i_data.cy[27]) begin
            n_data.cx = i_data.cx + w_sy;
            n_data.cy = i_data.cy - w_sx;
            n_data.cz = i_data.cz + atan_lut(i_idx);
        end else begin
            n_data.cx = i_data.cx - w_sy;
            n_data.cy = i_data.cy + w_sx;
            n_data.cz = i_data.cz - atan_lut(i_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_data <= n_data;
        end
    end

endmodule

// ----- rtl/trds_div_cell.sv -----
// ----------------------------------------------------------------------------
// Divider cell
// One pipeline cell of two restoring dividers: each lane produces one
// quotient bit and hands its remainder to the next cell.
// ----------------------------------------------------------------------------
module trds_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  trds_pkg::t_pipe i_data,
    output logic           o_vld,
    output trds_pkg::t_pipe o_data
);
    import trds_pkg::*;

    t_pipe       n_data;
    logic [24:0] w_t   [2];
    logic        w_ge  [2];

    always_comb begin
        n_data = i_data;
        for (int k = 0; k < 2; k++) begin
            w_t[k]  = {i_data.lane[k].rem, i_data.lane[k].nb[16]};
            w_ge[k] = (w_t[k] >= {1'b0, i_data.lane[k].den});
            n_data.lane[k].rem = w_ge[k] ? 24'(w_t[k] - {1'b0, i_data.lane[k].den})
                                         : w_t[k][23:0];
            n_data.lane[k].nb  = {i_data.lane[k].nb[15:0], 1'b0};
            n_data.lane[k].quo = {i_data.lane[k].quo[15:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_data <= n_data;
        end
    end

endmodule

// ----- rtl/thumbstick_radial_deadzone_snap.sv -----
// ----------------------------------------------------------------------------
// Thumbstick radial dead zone with axis snap
// Conditions one stick sample pair: radial dead zone, rescale, cap and
// snapping of the direction to the nearest axis, with a Q1.15 vector out.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries raw_x in tdata[15:0] and raw_y in tdata[31:16].
//   The output stream carries out_x in tdata[15:0], out_y in tdata[31:16] and
//   the dead-zone flag in tuser. Configuration is a plain write port; write it
//   only while no item is in flight.
//   One item is taken every cycle unless the receiver stalls. The pipeline is
//   a chain of 24 cells that each form one square-root bit and one CORDIC
//   rotation, followed by two chains of 17 divider cells (magnitude rescale,
//   then component scaling), plus multiply, load and output stages.
//   Reset empties the pipeline and loads the dead zone with 10813 and the
//   snap half-window with 1820. When the receiver stalls with a result held
//   in the output register, the whole chain holds and input tready drops;
//   no item is lost.
// ----------------------------------------------------------------------------
module thumbstick_radial_deadzone_snap (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_addr,
    input  logic [14:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,    // raw_x [15:0], raw_y [31:16]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,    // out_x [15:0], out_y [31:16]
    output logic        o_m_axis_tuser     // in_dead_zone
);
    import trds_pkg::*;

    localparam logic [ANGLE_BITS:0] TURN = (ANGLE_BITS + 1)'(1) << ANGLE_BITS;

    logic [14:0] r_dead_zone;
    logic [13:0] r_snap_angle;

    logic        w_en;
    logic        r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld;
    t_pipe       r_s1, r_s2, r_s3, r_s4, r_s5;
    t_pipe       n_s1, n_s2, n_s3, n_s4, n_s5;

    logic        w_rc_vld [ROOT_STEPS+1];
    t_pipe       w_rc     [ROOT_STEPS+1];
    logic        w_dc_vld [DIV_STEPS+1];
    t_pipe       w_dc     [DIV_STEPS+1];
    logic        w_ec_vld [DIV_STEPS+1];
    t_pipe       w_ec     [DIV_STEPS+1];

    logic        r_out_vld;
    logic [15:0] r_out_x, r_out_y;
    logic        r_out_dz;
    logic [15:0] n_out_x, n_out_y;
    logic        n_out_dz;

    logic signed [31:0] w_xx, w_yy;
    logic [31:0]        w_m2;
    logic [27:0]        w_sxe, w_sye;
    logic [31:0]        w_zr;
    logic [23:0]        w_diff;
    logic [40:0]        w_num;
    logic [16:0]        w_ax, w_ay;
    logic [33:0]        w_pxf, w_pyf;
    logic [ANGLE_BITS-1:0] w_adiff [4];
    logic [ANGLE_BITS:0]   w_dist  [4];
    logic [3:0]            w_hit;
    logic [40:0]        w_nx, w_ny;
    logic [16:0]        w_q    [2];
    logic [15:0]        w_comp [2];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone  <= DEAD_ZONE_RST;
            r_snap_angle <= SNAP_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_DEAD_ZONE:  r_dead_zone  <= i_cfg_wdata;
                REG_SNAP_ANGLE: r_snap_angle <= i_cfg_wdata[13:0];
                default: ;
            endcase
        end
    end

    assign w_en            = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // Stage 1: squares of both axes and of the dead-zone radius.
    always_comb begin
        n_s1      = '0;
        n_s1.x    = i_s_axis_tdata[15:0];
        n_s1.y    = i_s_axis_tdata[31:16];
        n_s1.d    = r_dead_zone;
        n_s1.snap = r_snap_angle;
        w_xx      = n_s1.x * n_s1.x;
        w_yy      = n_s1.y * n_s1.y;
        n_s1.xx   = w_xx[30:0];
        n_s1.yy   = w_yy[30:0];
        n_s1.dd   = r_dead_zone * r_dead_zone;
    end

    // Stage 2: squared radius, range tests, root and CORDIC seeds.
    always_comb begin
        n_s2      = r_s1;
        w_m2      = {1'b0, r_s1.xx} + {1'b0, r_s1.yy};
        n_s2.dead = (w_m2 < {2'b00, r_s1.dd});
        n_s2.big  = (w_m2 > FULL_SCALE_SQ) || (r_s1.d == FULL_SCALE);
        n_s2.zero = (r_s1.x == 16'sd0) && (r_s1.y == 16'sd0);
        n_s2.sq_rem  = '0;
        n_s2.sq_root = '0;
        n_s2.sq_v    = {w_m2, 16'h0000};
        w_sxe = {{4{r_s1.x[15]}}, r_s1.x, 8'h00};
        w_sye = {{4{r_s1.y[15]}}, r_s1.y, 8'h00};
        // A left half-plane sample is turned by half a turn first.
        if (r_s1.x[15]) begin
            n_s2.cx = -$signed(w_sxe);
            n_s2.cy = -$signed(w_sye);
            n_s2.cz = 32'h8000_0000;
        end else begin
            n_s2.cx = $signed(w_sxe);
            n_s2.cy = $signed(w_sye);
            n_s2.cz = 32'h0000_0000;
        end
    end

    assign w_rc_vld[0] = r_s2_vld;
    assign w_rc[0]     = r_s2;

    for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_root
        trds_root_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_idx   (5'(g)),
            .i_vld   (w_rc_vld[g]),
            .i_data  (w_rc[g]),
            .o_vld   (w_rc_vld[g+1]),
            .o_data  (w_rc[g+1])
        );
    end

    // Stage 3: round the angle, load the magnitude divider.
    always_comb begin
        n_s3   = w_rc[ROOT_STEPS];
        w_zr   = w_rc[ROOT_STEPS].cz + (32'd1 << (31 - ANGLE_BITS));
        n_s3.ang = w_rc[ROOT_STEPS].zero ? '0 : w_zr[31 -: ANGLE_BITS];
        w_diff = w_rc[ROOT_STEPS].sq_root - {1'b0, w_rc[ROOT_STEPS].d, 8'h00};
        w_num  = 41'(w_diff) << 15;
        n_s3.lane[0].rem = w_num[40:17];
        n_s3.lane[0].nb  = w_num[16:0];
        n_s3.lane[0].den = {1'b0, FULL_SCALE - w_rc[ROOT_STEPS].d, 8'h00};
        n_s3.lane[0].quo = '0;
        n_s3.lane[1]     = '0;
    end

    assign w_dc_vld[0] = r_s3_vld;
    assign w_dc[0]     = r_s3;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_mag
        trds_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_dc_vld[g]),
            .i_data  (w_dc[g]),
            .o_vld   (w_dc_vld[g+1]),
            .o_data  (w_dc[g+1])
        );
    end

    // Stage 4: final magnitude, component products and axis snap decision.
    always_comb begin
        n_s4     = w_dc[DIV_STEPS];
        n_s4.mag = w_dc[DIV_STEPS].big ? MAG_ONE : w_dc[DIV_STEPS].lane[0].quo;
        w_ax     = w_dc[DIV_STEPS].x[15] ? 17'(-{w_dc[DIV_STEPS].x[15], w_dc[DIV_STEPS].x})
                                         : {1'b0, w_dc[DIV_STEPS].x};
        w_ay     = w_dc[DIV_STEPS].y[15] ? 17'(-{w_dc[DIV_STEPS].y[15], w_dc[DIV_STEPS].y})
                                         : {1'b0, w_dc[DIV_STEPS].y};
        w_pxf    = w_ax * n_s4.mag;
        w_pyf    = w_ay * n_s4.mag;
        n_s4.px  = w_pxf[30:0];
        n_s4.py  = w_pyf[30:0];
        for (int k = 0; k < 4; k++) begin
            w_adiff[k] = w_dc[DIV_STEPS].ang - {2'(k), {(ANGLE_BITS-2){1'b0}}};
            w_dist[k]  = w_adiff[k][ANGLE_BITS-1] ? (TURN - {1'b0, w_adiff[k]})
                                                  : {1'b0, w_adiff[k]};
            w_hit[k]   = (32'(w_dist[k]) <= 32'(w_dc[DIV_STEPS].snap));
        end
        // Overlapping windows resolve in the order east, north, west, south.
        n_s4.snap_hit = |w_hit;
        if (w_hit[0])      n_s4.snap_dir = 2'd0;
        else if (w_hit[1]) n_s4.snap_dir = 2'd1;
        else if (w_hit[2]) n_s4.snap_dir = 2'd2;
        else               n_s4.snap_dir = 2'd3;
    end

    // Stage 5: load both component dividers with rounding bias. Dividing
    // p * 256 + floor(root / 2) by the root rounds p * 256 / root to nearest.
    always_comb begin
        n_s5 = r_s4;
        w_nx = 41'({r_s4.px, 8'h00}) + 41'(r_s4.sq_root[23:1]);
        w_ny = 41'({r_s4.py, 8'h00}) + 41'(r_s4.sq_root[23:1]);
        n_s5.lane[0].rem = w_nx[40:17];
        n_s5.lane[0].nb  = w_nx[16:0];
        n_s5.lane[0].den = r_s4.sq_root;
        n_s5.lane[0].quo = '0;
        n_s5.lane[1].rem = w_ny[40:17];
        n_s5.lane[1].nb  = w_ny[16:0];
        n_s5.lane[1].den = r_s4.sq_root;
        n_s5.lane[1].quo = '0;
    end

    assign w_ec_vld[0] = r_s5_vld;
    assign w_ec[0]     = r_s5;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_scale
        trds_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_ec_vld[g]),
            .i_data  (w_ec[g]),
            .o_vld   (w_ec_vld[g+1]),
            .o_data  (w_ec[g+1])
        );
    end

    // Output selection with saturation to the Q1.15 range.
    always_comb begin
        w_q[0] = w_ec[DIV_STEPS].lane[0].quo;
        w_q[1] = w_ec[DIV_STEPS].lane[1].quo;
        for (int k = 0; k < 2; k++) begin
            if (w_ec[DIV_STEPS].sq_root == '0) begin
                w_comp[k] = '0;
            end else if ((k == 0) ? w_ec[DIV_STEPS].x[15] : w_ec[DIV_STEPS].y[15]) begin
                w_comp[k] = (w_q[k] > MAG_ONE) ? 16'h8000 : 16'(-w_q[k]);
            end else begin
                w_comp[k] = (w_q[k] > 17'd32767) ? 16'h7FFF : w_q[k][15:0];
            end
        end
        n_out_dz = 1'b0;
        n_out_x  = '0;
        n_out_y  = '0;
        if (w_ec[DIV_STEPS].dead) begin
            n_out_dz = 1'b1;
        end else if (w_ec[DIV_STEPS].snap_hit) begin
            case (w_ec[DIV_STEPS].snap_dir)
                2'd0: n_out_x = (w_ec[DIV_STEPS].mag == MAG_ONE) ? 16'h7FFF
                                                                 : w_ec[DIV_STEPS].mag[15:0];
                2'd1: n_out_y = (w_ec[DIV_STEPS].mag == MAG_ONE) ? 16'h7FFF
                                                                 : w_ec[DIV_STEPS].mag[15:0];
                2'd2: n_out_x = 16'(-w_ec[DIV_STEPS].mag);
                default: n_out_y = 16'(-w_ec[DIV_STEPS].mag);
            endcase
        end else begin
            n_out_x = w_comp[0];
            n_out_y = w_comp[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld  <= i_s_axis_tvalid;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= w_rc_vld[ROOT_STEPS];
            r_s4_vld  <= w_dc_vld[DIV_STEPS];
            r_s5_vld  <= r_s4_vld;
            r_out_vld <= w_ec_vld[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1     <= n_s1;
            r_s2     <= n_s2;
            r_s3     <= n_s3;
            r_s4     <= n_s4;
            r_s5     <= n_s5;
            r_out_x  <= n_out_x;
            r_out_y  <= n_out_y;
            r_out_dz <= n_out_dz;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_out_y, r_out_x};
    assign o_m_axis_tuser  = r_out_dz;

    // A sample outside the dead zone has a root of at least the dead radius.
    a_root_above_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_vld && !r_s3.dead |-> r_s3.sq_root >= {1'b0, r_s3.d, 8'h00})
        else $error("square root below dead-zone radius");

    // The rescaled magnitude never exceeds full scale.
    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_vld && !r_s4.dead |-> r_s4.mag <= MAG_ONE)
        else $error("magnitude out of range");

    // A dead-zone result carries a zero vector.
    a_dead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_dz |-> r_out_x == 16'h0000 && r_out_y == 16'h0000)
        else $error("dead-zone item with nonzero vector");

    // A snapped result lies on an axis.
    a_snap_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && w_ec_vld[DIV_STEPS] && w_ec[DIV_STEPS].snap_hit && !w_ec[DIV_STEPS].dead
        |=> r_out_x == 16'h0000 || r_out_y == 16'h0000)
        else $error("snapped item off axis");

endmodule
